// ===== design/tgl_pkg.sv =====
// Package for the turtle graphics line generator: command and status codes,
// CORDIC constants and the arctangent table. No dependencies.
package tgl_pkg;

    localparam logic [2:0] FUNC_FWD   = 3'd0;
    localparam logic [2:0] FUNC_RIGHT = 3'd1;
    localparam logic [2:0] FUNC_LEFT  = 3'd2;
    localparam logic [2:0] FUNC_PUSH  = 3'd3;
    localparam logic [2:0] FUNC_POP   = 3'd4;

    localparam logic [1:0] STATUS_LINE  = 2'd0;
    localparam logic [1:0] STATUS_OVER  = 2'd1;
    localparam logic [1:0] STATUS_UNDER = 2'd2;

    localparam logic       CFG_STEP  = 1'b0;
    localparam logic       CFG_ANGLE = 1'b1;

    localparam int CORDIC_ITERS = 16;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
    localparam logic [15:0] HEADING_BASE = 16'd49152;

    // CORDIC working width: |x0| < 2^49, growth under 2 gives margin
    localparam int CW = 52;
    typedef logic signed [CW-1:0] cval_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        heading;
    } pose_t;

    function automatic logic signed [31:0] atan_lookup(input logic [3:0] i);
        case (i)
            4'd0:    atan_lookup = 32'sh20000000;
            4'd1:    atan_lookup = 32'sh12E4051D;
            4'd2:    atan_lookup = 32'sh09FB385B;
            4'd3:    atan_lookup = 32'sh051111D4;
            4'd4:    atan_lookup = 32'sh028B0D43;
            4'd5:    atan_lookup = 32'sh0145D7E1;
            4'd6:    atan_lookup = 32'sh00A2F61E;
            4'd7:    atan_lookup = 32'sh00517C55;
            4'd8:    atan_lookup = 32'sh0028BE53;
            4'd9:    atan_lookup = 32'sh00145F2E;
            4'd10:   atan_lookup = 32'sh000A2F98;
            4'd11:   atan_lookup = 32'sh000517CC;
            4'd12:   atan_lookup = 32'sh00028BE6;
            4'd13:   atan_lookup = 32'sh000145F3;
            4'd14:   atan_lookup = 32'sh0000A2F9;
            default: atan_lookup = 32'sh0000517C;
        endcase
    endfunction

endpackage

// ===== design/tgl_stack.sv =====
// Pose stack memory for the turtle graphics line generator.
// Depends on tgl_pkg (pose_t). One write port and one read port, registered read.
module tgl_stack
    import tgl_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  pose_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output pose_t         rd_data
);

    pose_t mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/tgl_cordic.sv =====
// Iterative CORDIC rotator: scales a Q15.16 distance by the gain, rotates it
// by a 16-bit heading one iteration a cycle. Depends on tgl_pkg.
module tgl_cordic
    import tgl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] distance,
    input  logic [15:0]        angle,
    output logic               done,
    output logic signed [33:0] dx,
    output logic signed [33:0] dy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ITER = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [3:0]         iter_reg;
    logic signed [63:0] prod_reg;
    logic [15:0]        ang_reg;
    cval_t              x_reg, y_reg;
    logic signed [33:0] z_reg;

    cval_t              x0, xs, ys, xr, yr;
    logic signed [33:0] at;

    // gain-scaled start value, floor shift
    assign x0 = cval_t'(prod_reg >>> 14);
    assign xs = x_reg >>> iter_reg;
    assign ys = y_reg >>> iter_reg;
    assign at = 34'(atan_lookup(iter_reg));
    assign xr = (x_reg + cval_t'(32768)) >>> 16;
    assign yr = (y_reg + cval_t'(32768)) >>> 16;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_MUL;
            S_MUL:   state_next = S_ITER;
            S_ITER:  if (iter_reg == 4'(CORDIC_ITERS - 1)) state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_ITER) iter_reg <= iter_reg + 4'd1;
            else                     iter_reg <= '0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                prod_reg <= 64'(distance) * $signed({32'd0, CORDIC_GAIN});
                ang_reg  <= angle;
            end
            S_MUL: begin
                case (ang_reg[15:14])
                    2'd0:    begin x_reg <= x0;   y_reg <= '0;  end
                    2'd1:    begin x_reg <= '0;   y_reg <= x0;  end
                    2'd2:    begin x_reg <= -x0;  y_reg <= '0;  end
                    default: begin x_reg <= '0;   y_reg <= -x0; end
                endcase
                z_reg <= $signed({4'd0, ang_reg[13:0], 16'd0});
            end
            S_ITER: begin
                if (!z_reg[33]) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
            end
            default: ;
        endcase
    end

    // rounded step; magnitude stays near 2^31, so 34 bits hold it whole
    assign done = (state_reg == S_DONE);
    assign dx   = xr[33:0];
    assign dy   = yr[33:0];

endmodule

// ===== design/turtle_graphics_line_generator.sv =====
// Turtle graphics line generator: takes one decoded command per beat (forward,
// turn right/left, push, pop, no-op) and emits line segments or stack errors.
// Depends on tgl_pkg, tgl_cordic and tgl_stack.
//
// A forward move starts the rotator, which registers the gain-scaled distance,
// loads the quadrant-rotated start value, runs 16 CORDIC iterations and then
// presents the rounded step; this is added to the pose, saturated and registered
// as the result. A pop reads the pose stack memory through its registered read
// port. One item is in work at a time; a waiting result sits in an output
// register and the next item is taken once it has been sent. The pose stack has
// STACK_DEPTH entries and needs no clearing after reset.
module turtle_graphics_line_generator
    import tgl_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_func,
    input  logic               s_use_amount,
    input  logic signed [31:0] s_amount,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_start_x,
    output logic signed [31:0] m_start_y,
    output logic signed [31:0] m_end_x,
    output logic signed [31:0] m_end_y
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNTW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_ROT  = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [30:0]        step_reg;
    logic [15:0]        angle_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [15:0]        head_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic [2:0]         func_reg;
    logic               use_reg;
    logic signed [31:0] amt_reg;
    logic               cordic_start;
    logic               cordic_done;
    logic signed [33:0] dx, dy;
    logic signed [34:0] ex_sum, ey_sum;
    logic signed [31:0] ex_sat, ey_sat;
    logic [15:0]        turn;
    logic               st_we;
    logic [AW-1:0]      st_waddr, st_raddr;
    pose_t              st_wdata, st_rdata;

    assign s_ready = (state_reg == S_IDLE) && !m_valid;
    assign turn = use_reg ? amt_reg[15:0] : angle_reg;

    // pose stack
    assign st_we    = (state_reg == S_EXEC) && (func_reg == FUNC_PUSH) &&
                      (cnt_reg < CNTW'(STACK_DEPTH));
    assign st_waddr = cnt_reg[AW-1:0];
    assign st_raddr = AW'(cnt_reg - CNTW'(1));
    assign st_wdata = '{x: x_reg, y: y_reg, heading: head_reg};

    tgl_stack #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    assign cordic_start = (state_reg == S_EXEC) && (func_reg == FUNC_FWD);

    tgl_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cordic_start),
        .distance (use_reg ? amt_reg : {1'b0, step_reg}),
        .angle    (head_reg),
        .done     (cordic_done),
        .dx       (dx),
        .dy       (dy)
    );

    // saturating end point on the full-width sum
    assign ex_sum = 35'(x_reg) + 35'(dx);
    assign ey_sum = 35'(y_reg) + 35'(dy);
    always_comb begin
        if (ex_sum[34:31] != {4{ex_sum[34]}})
            ex_sat = ex_sum[34] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            ex_sat = ex_sum[31:0];
        if (ey_sum[34:31] != {4{ey_sum[34]}})
            ey_sat = ey_sum[34] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            ey_sat = ey_sum[31:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid && s_ready) state_next = S_EXEC;
            S_EXEC: begin
                case (func_reg)
                    FUNC_FWD: state_next = S_ROT;
                    FUNC_POP: state_next = (cnt_reg == '0) ? S_OUT : S_POP;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_ROT:   if (cordic_done) state_next = S_IDLE;
            S_POP:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= 31'd65536;
            angle_reg <= 16'd16384;
            head_reg  <= HEADING_BASE + 16'd16384;
            x_reg     <= '0;
            y_reg     <= '0;
            cnt_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) m_valid <= 1'b0;
            // configuration writes
            if (cfg_we) begin
                if (cfg_index == CFG_STEP) begin
                    step_reg <= cfg_data;
                end else begin
                    angle_reg <= cfg_data[15:0];
                    head_reg  <= HEADING_BASE + cfg_data[15:0];
                end
            end
            case (state_reg)
                S_EXEC: begin
                    case (func_reg)
                        FUNC_RIGHT: head_reg <= head_reg - turn;
                        FUNC_LEFT:  head_reg <= head_reg + turn;
                        FUNC_PUSH: begin
                            if (cnt_reg < CNTW'(STACK_DEPTH)) begin
                                cnt_reg <= cnt_reg + CNTW'(1);
                            end else begin
                                m_valid  <= 1'b1;
                                m_status <= STATUS_OVER;
                                m_start_x <= '0; m_start_y <= '0;
                                m_end_x <= '0;   m_end_y <= '0;
                            end
                        end
                        FUNC_POP: begin
                            if (cnt_reg == '0) begin
                                m_valid  <= 1'b1;
                                m_status <= STATUS_UNDER;
                                m_start_x <= '0; m_start_y <= '0;
                                m_end_x <= '0;   m_end_y <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_ROT: begin
                    if (cordic_done) begin
                        x_reg     <= ex_sat;
                        y_reg     <= ey_sat;
                        m_valid   <= 1'b1;
                        m_status  <= STATUS_LINE;
                        m_start_x <= x_reg;
                        m_start_y <= y_reg;
                        m_end_x   <= ex_sat;
                        m_end_y   <= ey_sat;
                    end
                end
                S_POP: begin
                    cnt_reg  <= cnt_reg - CNTW'(1);
                    x_reg    <= st_rdata.x;
                    y_reg    <= st_rdata.y;
                    head_reg <= st_rdata.heading;
                end
                default: ;
            endcase
        end
    end

    // latch the accepted command
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            use_reg  <= s_use_amount;
            amt_reg  <= s_amount;
        end
    end

`ifndef SYNTH
    // stack fill never exceeds its depth
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNTW'(STACK_DEPTH))
        else $error("stack count out of range");
    // no item is taken while a result waits or work is under way
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IDLE && !m_valid))
        else $error("input taken while busy");
    // a segment result is produced only when the rotator finishes
    a_seg_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && m_status == STATUS_LINE |-> $past(cordic_done))
        else $error("segment without rotation");
`endif

endmodule
